// ===== src/t2gss_pkg.sv =====
// shared types, constants and table helper for the top-2 gating softmax block
package t2gss_pkg;

    // logit class codes
    localparam logic [1:0] CLASS_FINITE = 2'd0;
    localparam logic [1:0] CLASS_PINF   = 2'd1;
    localparam logic [1:0] CLASS_MINF   = 2'd2;
    localparam logic [1:0] CLASS_NAN    = 2'd3;

    // rank keys: minus infinity lowest, finite in the middle, plus infinity on top
    localparam int          KEY_W    = 17;
    localparam logic [16:0] KEY_MINF = 17'd0;
    localparam logic [16:0] KEY_PINF = 17'd65537;

    // weights in q1.16
    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    // exp(-1/16) in q0.32
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748386;

    // parameter defaults
    localparam int DEF_MAX_EXPERTS     = 256;
    localparam int DEF_SIGMOID_ENTRIES = 256;

    // configuration port
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 16;
    localparam logic [0:0] CFG_NUM_EXPERTS = 1'b0;
    localparam logic [0:0] CFG_NUM_TOKENS  = 1'b1;
    localparam logic [8:0] RESET_NUM_EXPERTS = 9'd8;

    // input word
    typedef struct packed {
        logic signed [15:0] logit_value;
        logic [1:0]         value_class;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [7:0]  first_expert;
        logic [7:0]  second_expert;
        logic [16:0] first_gate;
        logic [16:0] second_gate;
        logic        last_token;
    } t_out_word;

    // finished token handed to the weight stage
    typedef struct packed {
        logic [16:0] best_key;
        logic [16:0] runner_key;
        logic [7:0]  best_id;
        logic [7:0]  runner_id;
        logic        saw_real;
        logic        last_token;
    } t_snap;

    // rank key of one logit, nan ranks as minus infinity
    function automatic logic [16:0] rank_key(input logic [1:0] cls, input logic [15:0] val);
        logic [16:0] key;
        begin
            case (cls)
                CLASS_PINF:   key = KEY_PINF;
                CLASS_FINITE: key = {1'b0, val ^ 16'h8000} + 17'd1;
                default:      key = KEY_MINF;
            endcase
            return key;
        end
    endfunction

    // about 2^32 * exp(-n/16), built by repeated rounded multiplication
    function automatic logic [63:0] sig_exp_q32(input int n);
        logic [63:0] e;
        begin
            e = 64'h1_0000_0000;
            for (int k = 0; k < n; k++) begin
                e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
            end
            return e;
        end
    endfunction

endpackage

// ===== src/top2_gate_selected_softmax.sv =====
// top level: top-2 expert selection with two-way softmax gate weights
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one expert logit
// per word, num_experts words per token, expert ids counting from 0 in order.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one word per
// token: the two winning ids, their q1.16 gate weights and the last-token flag.
// The config port writes num_experts (index 0) and num_tokens (index 1) with
// no wait; write only while no token is in flight.
// Throughput: one logit per cycle while o_in_ready is high, with the
// compare-and-update of the running top two done in the cycle the word is taken.
// The result of a token loads the finished-token register when its last logit
// is accepted, then the output register through the sigmoid table once the
// output is free, and from there drives o_out_valid.
// Reset clears the running top two, both counters and both pipeline valids;
// num_experts returns to 8 and num_tokens to 0.
// When the receiver stalls, the output word holds and one more finished token
// waits in the middle register; logits of the following token keep flowing
// until that token ends too, then o_in_ready drops.
module top2_gate_selected_softmax #(
    parameter int MAX_EXPERTS     = t2gss_pkg::DEF_MAX_EXPERTS,
    parameter int SIGMOID_ENTRIES = t2gss_pkg::DEF_SIGMOID_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  t2gss_pkg::t_in_word                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output t2gss_pkg::t_out_word                o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [t2gss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [t2gss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int         CNT_W = (MAX_EXPERTS > 2) ? $clog2(MAX_EXPERTS) : 1;
    localparam logic [8:0] MAX_N = 9'(MAX_EXPERTS);

    // configuration registers
    logic [8:0]  r_num_experts;
    logic [15:0] r_num_tokens;

    // running top two of the current token
    logic [16:0]      r_best_key;
    logic [7:0]       r_best_id;
    logic             r_best_present;
    logic [16:0]      r_runner_key;
    logic [7:0]       r_runner_id;
    logic             r_runner_present;
    logic             r_saw_real;
    logic [CNT_W-1:0] r_expert_cnt;
    logic [15:0]      r_token_cnt;

    // finished-token register and output register
    logic                 r_snap_valid;
    t2gss_pkg::t_snap     r_snap;
    logic                 r_out_valid;
    t2gss_pkg::t_out_word r_out;

    logic [16:0]          n_best_key;
    logic [7:0]           n_best_id;
    logic [16:0]          n_runner_key;
    logic [7:0]           n_runner_id;
    logic                 n_saw_real;
    logic                 n_last_token;
    logic [15:0]          n_token_cnt;
    logic [1:0]           w_class;
    logic [16:0]          w_key;
    logic [7:0]           w_id;
    logic [8:0]           w_count;
    logic                 w_beats_best;
    logic                 w_beats_runner;
    logic                 w_tok_end;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_snap_move;
    t2gss_pkg::t_out_word w_word;

    // handshake: the middle register frees up whenever the output can take it,
    // logits that do not end a token never need it
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_snap_move = r_snap_valid && w_out_free;
    assign o_in_ready  = !r_snap_valid || w_out_free || !w_tok_end;
    assign w_accept    = i_in_valid && o_in_ready;

    // logits per token, clamped to the supported range
    always_comb begin
        if (r_num_experts < 9'd2) begin
            w_count = 9'd2;
        end else if (r_num_experts > MAX_N) begin
            w_count = MAX_N;
        end else begin
            w_count = r_num_experts;
        end
    end

    // rank of the incoming logit against the running top two
    assign w_class   = (i_in_data.value_class == t2gss_pkg::CLASS_NAN) ?
                       t2gss_pkg::CLASS_MINF : i_in_data.value_class;
    assign w_key     = t2gss_pkg::rank_key(w_class, i_in_data.logit_value);
    assign w_id      = 8'(r_expert_cnt);
    assign w_tok_end = ((9'(r_expert_cnt) + 9'd1) >= w_count);

    assign w_beats_best   = !r_best_present || (w_key > r_best_key) ||
                            ((w_key == r_best_key) && (w_id < r_best_id));
    assign w_beats_runner = !r_runner_present || (w_key > r_runner_key) ||
                            ((w_key == r_runner_key) && (w_id < r_runner_id));

    // updated top two including the incoming logit
    always_comb begin
        n_best_key   = r_best_key;
        n_best_id    = r_best_id;
        n_runner_key = r_runner_key;
        n_runner_id  = r_runner_id;
        if (w_beats_best) begin
            n_runner_key = r_best_key;
            n_runner_id  = r_best_id;
            n_best_key   = w_key;
            n_best_id    = w_id;
        end else if (w_beats_runner) begin
            n_runner_key = w_key;
            n_runner_id  = w_id;
        end
    end

    assign n_saw_real   = r_saw_real || (i_in_data.value_class != t2gss_pkg::CLASS_NAN);
    assign n_last_token = (r_num_tokens != 16'd0) &&
                          (({1'b0, r_token_cnt} + 17'd1) >= {1'b0, r_num_tokens});
    assign n_token_cnt  = n_last_token ? 16'd0 : (r_token_cnt + 16'd1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_experts <= t2gss_pkg::RESET_NUM_EXPERTS;
            r_num_tokens  <= 16'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                t2gss_pkg::CFG_NUM_EXPERTS: r_num_experts <= i_cfg_data[8:0];
                t2gss_pkg::CFG_NUM_TOKENS:  r_num_tokens  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // running state, cleared at the end of each token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_key       <= t2gss_pkg::KEY_MINF;
            r_best_id        <= 8'd0;
            r_best_present   <= 1'b0;
            r_runner_key     <= t2gss_pkg::KEY_MINF;
            r_runner_id      <= 8'd0;
            r_runner_present <= 1'b0;
            r_saw_real       <= 1'b0;
            r_expert_cnt     <= '0;
            r_token_cnt      <= 16'd0;
        end else if (w_accept) begin
            if (w_tok_end) begin
                r_best_key       <= t2gss_pkg::KEY_MINF;
                r_best_id        <= 8'd0;
                r_best_present   <= 1'b0;
                r_runner_key     <= t2gss_pkg::KEY_MINF;
                r_runner_id      <= 8'd0;
                r_runner_present <= 1'b0;
                r_saw_real       <= 1'b0;
                r_expert_cnt     <= '0;
                r_token_cnt      <= n_token_cnt;
            end else begin
                r_best_key       <= n_best_key;
                r_best_id        <= n_best_id;
                r_best_present   <= 1'b1;
                r_runner_key     <= n_runner_key;
                r_runner_id      <= n_runner_id;
                r_runner_present <= r_best_present;
                r_saw_real       <= n_saw_real;
                r_expert_cnt     <= CNT_W'(r_expert_cnt + 1'b1);
            end
        end
    end

    // finished-token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_accept && w_tok_end) begin
            r_snap_valid <= 1'b1;
        end else if (w_snap_move) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_tok_end) begin
            r_snap.best_key   <= n_best_key;
            r_snap.best_id    <= n_best_id;
            r_snap.runner_key <= n_runner_key;
            r_snap.runner_id  <= n_runner_id;
            r_snap.saw_real   <= n_saw_real;
            r_snap.last_token <= n_last_token;
        end
    end

    // gate weights of the finished token
    t2gss_weight #(
        .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
    ) u_weight (
        .i_snap(r_snap),
        .o_word(w_word)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_move) begin
            r_out <= w_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // the two reported experts are always distinct
    a_ids_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.first_expert != o_out_data.second_expert))
        else $error("first and second expert ids are equal");

    // the first expert never gets less than half the gate
    a_first_heavier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.first_gate >= t2gss_pkg::HALF_Q16))
        else $error("first weight below one half");

    // a token that ends always lands in the finished-token register
    a_token_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_tok_end) |=> r_snap_valid)
        else $error("finished token not captured");
`endif

endmodule

// ===== src/t2gss_weight.sv =====
// gate weight stage: sigmoid table lookup and special cases for one finished token
module t2gss_weight #(
    parameter int SIGMOID_ENTRIES = t2gss_pkg::DEF_SIGMOID_ENTRIES
) (
    input  t2gss_pkg::t_snap     i_snap,
    output t2gss_pkg::t_out_word o_word
);

    localparam int IDX_W = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;

    logic [16:0] w_table [SIGMOID_ENTRIES];
    logic [16:0] w_diff;
    logic [12:0] w_idx;
    logic        w_in_table;
    logic [16:0] w_first;

    // sigmoid table, entry i = round(2^48 / (2^32 + 2^32 * exp(-i/16)))
    for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_tab
        localparam logic [63:0] DEN = 64'h1_0000_0000 + t2gss_pkg::sig_exp_q32(g);
        localparam logic [63:0] QUO = (64'h1_0000_0000_0000 + (DEN >> 1)) / DEN;
        assign w_table[g] = QUO[16:0];
    end

    // gap between first and second rank, one entry per 1/16
    assign w_diff     = i_snap.best_key - i_snap.runner_key;
    assign w_idx      = w_diff[16:4];
    assign w_in_table = ({1'b0, w_idx} < 14'(SIGMOID_ENTRIES));

    // first weight with the equal-rank, infinite-gap and all-nan cases
    always_comb begin
        if (!i_snap.saw_real || (i_snap.best_key == i_snap.runner_key)) begin
            w_first = t2gss_pkg::HALF_Q16;
        end else if ((i_snap.best_key == t2gss_pkg::KEY_PINF) ||
                     (i_snap.runner_key == t2gss_pkg::KEY_MINF)) begin
            w_first = t2gss_pkg::ONE_Q16;
        end else if (w_in_table) begin
            w_first = w_table[w_idx[IDX_W-1:0]];
        end else begin
            w_first = t2gss_pkg::ONE_Q16;
        end
    end

    // result word, all-nan token reports ids 0 and 1
    always_comb begin
        o_word.first_expert  = i_snap.saw_real ? i_snap.best_id   : 8'd0;
        o_word.second_expert = i_snap.saw_real ? i_snap.runner_id : 8'd1;
        o_word.first_gate    = w_first;
        o_word.second_gate   = t2gss_pkg::ONE_Q16 - w_first;
        o_word.last_token    = i_snap.last_token;
    end

endmodule
